// ===== hdl/mte_pkg.sv =====
// Shared constants, register codes and saturation helpers for the matrix exponential unit
package mte_pkg;

    localparam int DATA_W        = 32;
    localparam int DIM_W         = 3;
    localparam int TERMS_W       = 7;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 7;
    localparam int MAX_DIM_DEF   = 4;
    localparam int FRAC_BITS_DEF = 24;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIM   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TERMS = 2'd1;

    localparam logic [DIM_W-1:0]   DIM_RESET   = 3'd4;
    localparam logic [TERMS_W-1:0] TERMS_RESET = 7'd100;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    // clamp a 64-bit value into the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] res;
        if (v > S32_MAX) begin
            res = 32'sh7fff_ffff;
        end else if (v < S32_MIN) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

    // true when sat32 would clamp
    function automatic logic ovf32(input logic signed [63:0] v);
        return (v > S32_MAX) || (v < S32_MIN);
    endfunction

endpackage

// ===== hdl/mte_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module mte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/mte_mul.sv =====
// Registered fixed-point multiplier: exact product, round half up, arithmetic shift
module mte_mul #(
    parameter int FRAC_BITS = 24
) (
    input  logic                      i_clk,
    input  logic signed [31:0]        i_a,
    input  logic signed [31:0]        i_b,
    output logic signed [63:0]        o_p
);
    import mte_pkg::*;

    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    logic signed [63:0] w_prod;
    logic signed [63:0] r_p;

    assign w_prod = 64'(i_a) * 64'(i_b);

    always_ff @(posedge i_clk) begin
        r_p <= (w_prod + HALF) >>> FRAC_BITS;
    end

    assign o_p = r_p;
endmodule

// ===== hdl/mte_div.sv =====
// Iterative restoring divider, one quotient bit per cycle
module mte_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    import mte_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W:0]   w_shift;
    logic [DEN_W:0]   w_diff;
    logic             w_fit;

    // trial subtract of the divisor from the shifted partial remainder
    assign w_shift = {r_rem, r_quo[NUM_W-1]};
    assign w_fit   = (w_shift >= {1'b0, r_den});
    assign w_diff  = w_shift - {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule

// ===== hdl/matrix_exponential_taylor_unit.sv =====
// Top level: matrix load, Taylor series sequencer and result streaming
//
// Usage
//   Input channel (i_in_valid / o_in_ready): one beat per matrix element,
//   row-major; time value is taken from the first beat of each load, and the
//   beat with i_last_element high starts the series. Beats beyond n*n are
//   dropped. Config channel (i_cfg_valid / o_cfg_ready, always ready) writes
//   the matrix order and the term limit; write only while the unit is idle.
//   Output channel (o_out_valid / i_out_ready): n*n beats of exp(A*T),
//   row-major, o_last_result on the final beat, o_saturated on every beat.
// Sequencing
//   Each load beat is scaled through the shared multiplier before the next is
//   accepted. Each series term does the n multiply-accumulates of every entry
//   in the shared multiplier and a bit-serial divide per entry, then an update
//   pass; up to max_terms terms. Output beats pass through ST_EM_ADDR, ST_EM_LOAD
//   and ST_EM_SEND. o_in_ready is low while a beat is scaled and, after the
//   last beat, until the last result beat is taken.
// Reset clears the sequencer, load counter, flags and registers to 4 / 100.
// A stalled receiver simply holds the current result beat; nothing is lost.
module matrix_exponential_taylor_unit #(
    parameter int MAX_DIM   = mte_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = mte_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mte_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mte_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // matrix elements in
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [mte_pkg::DATA_W-1:0] i_a_element,
    input  logic signed [mte_pkg::DATA_W-1:0] i_time_value,
    input  logic                              i_last_element,
    // results out
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [mte_pkg::DATA_W-1:0] o_f_element,
    output logic                              o_last_result,
    output logic                              o_saturated
);
    import mte_pkg::*;

    localparam int CELLS = MAX_DIM * MAX_DIM;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW    = $clog2(MAX_DIM + 1);
    localparam int LW    = $clog2(CELLS + 1);
    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sd1 <<< FRAC_BITS;

    typedef enum logic [14:0] {
        ST_IDLE     = 15'b000_0000_0000_0001,
        ST_LD_MUL   = 15'b000_0000_0000_0010,
        ST_LD_WR    = 15'b000_0000_0000_0100,
        ST_INIT     = 15'b000_0000_0000_1000,
        ST_MAC_ADDR = 15'b000_0000_0001_0000,
        ST_MAC_MUL  = 15'b000_0000_0010_0000,
        ST_MAC_ACC  = 15'b000_0000_0100_0000,
        ST_DIV_GO   = 15'b000_0000_1000_0000,
        ST_DIV_WAIT = 15'b000_0001_0000_0000,
        ST_CHECK    = 15'b000_0010_0000_0000,
        ST_UPD_ADDR = 15'b000_0100_0000_0000,
        ST_UPD_WR   = 15'b000_1000_0000_0000,
        ST_EM_ADDR  = 15'b001_0000_0000_0000,
        ST_EM_LOAD  = 15'b010_0000_0000_0000,
        ST_EM_SEND  = 15'b100_0000_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic [DIM_W-1:0]          r_dim;
    logic [TERMS_W-1:0]        r_terms;
    logic [LW-1:0]             r_load_index;
    logic signed [DATA_W-1:0]  r_time;
    logic signed [DATA_W-1:0]  r_a;
    logic                      r_last;
    logic                      r_sat;
    logic [TERMS_W-1:0]        r_step;
    logic signed [63:0]        r_acc;
    logic                      r_all_zero;
    logic                      r_neg;
    logic [CW-1:0]             r_row, r_col, r_k;
    logic                      r_out_valid;
    logic signed [DATA_W-1:0]  r_f;
    logic                      r_olast;
    logic                      r_osat;

    logic [CW-1:0]             w_n, w_nm1;
    logic [LW-1:0]             w_cnt;
    logic [CW-1:0]             w_ld_row, w_ld_col;
    logic                      w_col_end, w_row_end, w_cell_end;
    logic                      w_in_acc;

    logic signed [DATA_W-1:0]  w_s_rd, w_t_rd, w_u_rd, w_p_rd;
    logic signed [DATA_W-1:0]  w_ident;
    logic signed [63:0]        w_upd;
    logic signed [DATA_W-1:0]  w_acc_sat;
    logic [DATA_W-1:0]         w_mag;
    logic [DATA_W-1:0]         w_quot;
    logic signed [DATA_W-1:0]  w_term;
    logic                      w_div_done;
    logic signed [DATA_W-1:0]  w_mul_a, w_mul_b;
    logic signed [63:0]        w_mul_p;
    logic                      w_ts_we;

    // flat store address of (row, col)
    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] row,
                                                input logic [CW-1:0] col);
        return AW'(int'(row) * MAX_DIM + int'(col));
    endfunction

    // effective matrix order
    always_comb begin
        if (r_dim == '0) begin
            w_n = CW'(1);
        end else if (int'(r_dim) > MAX_DIM) begin
            w_n = CW'(MAX_DIM);
        end else begin
            w_n = CW'(r_dim);
        end
    end
    assign w_nm1 = w_n - 1'b1;
    assign w_cnt = LW'(int'(w_n) * int'(w_n));

    // split the load index into row and column
    always_comb begin
        w_ld_row = '0;
        for (int j = 1; j < MAX_DIM; j++) begin
            if (int'(r_load_index) >= j * int'(w_n)) begin
                w_ld_row = CW'(j);
            end
        end
        w_ld_col = CW'(int'(r_load_index) - int'(w_ld_row) * int'(w_n));
    end

    assign w_col_end  = (r_col == w_nm1);
    assign w_row_end  = (r_row == w_nm1);
    assign w_cell_end = w_col_end && w_row_end;
    assign w_in_acc   = i_in_valid && o_in_ready;

    // shared multiplier: scaling on load, term products in the series
    assign w_mul_a = (r_state == ST_LD_MUL) ? r_a    : w_t_rd;
    assign w_mul_b = (r_state == ST_LD_MUL) ? r_time : w_s_rd;

    mte_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    // division of each product entry by the term number
    assign w_acc_sat = sat32(r_acc);
    assign w_mag     = w_acc_sat[DATA_W-1] ? DATA_W'(-w_acc_sat) : DATA_W'(w_acc_sat);

    mte_div #(.NUM_W(DATA_W), .DEN_W(TERMS_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_DIV_GO),
        .i_num   (w_mag + DATA_W'(r_step >> 1)),
        .i_den   (r_step),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_term  = r_neg ? -signed'(w_quot) : signed'(w_quot);
    assign w_ident = (r_row == r_col) ? Q_ONE : '0;
    assign w_upd   = 64'(w_u_rd) + 64'(w_p_rd);
    assign w_ts_we = (r_state == ST_INIT) || (r_state == ST_UPD_WR);

    // matrix stores
    mte_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_scaled (
        .i_clk   (i_clk),
        .i_we    ((r_state == ST_LD_WR) && (r_load_index < w_cnt)),
        .i_waddr (cell_addr(w_ld_row, w_ld_col)),
        .i_wdata (sat32(w_mul_p)),
        .i_raddr (cell_addr(r_k, r_col)),
        .o_rdata (w_s_rd)
    );

    mte_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_term (
        .i_clk   (i_clk),
        .i_we    (w_ts_we),
        .i_waddr (cell_addr(r_row, r_col)),
        .i_wdata ((r_state == ST_INIT) ? w_ident : w_p_rd),
        .i_raddr (cell_addr(r_row, r_k)),
        .o_rdata (w_t_rd)
    );

    mte_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_sum (
        .i_clk   (i_clk),
        .i_we    (w_ts_we),
        .i_waddr (cell_addr(r_row, r_col)),
        .i_wdata ((r_state == ST_INIT) ? w_ident : sat32(w_upd)),
        .i_raddr (cell_addr(r_row, r_col)),
        .o_rdata (w_u_rd)
    );

    mte_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_prod (
        .i_clk   (i_clk),
        .i_we    ((r_state == ST_DIV_WAIT) && w_div_done),
        .i_waddr (cell_addr(r_row, r_col)),
        .i_wdata (w_term),
        .i_raddr (cell_addr(r_row, r_col)),
        .o_rdata (w_p_rd)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (w_in_acc) n_state = ST_LD_MUL;
            ST_LD_MUL:   n_state = ST_LD_WR;
            ST_LD_WR:    n_state = r_last ? ST_INIT : ST_IDLE;
            ST_INIT: begin
                if (w_cell_end) begin
                    n_state = (r_terms == '0) ? ST_EM_ADDR : ST_MAC_ADDR;
                end
            end
            ST_MAC_ADDR: n_state = ST_MAC_MUL;
            ST_MAC_MUL:  n_state = ST_MAC_ACC;
            ST_MAC_ACC:  n_state = (r_k == w_nm1) ? ST_DIV_GO : ST_MAC_ADDR;
            ST_DIV_GO:   n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = w_cell_end ? ST_CHECK : ST_MAC_ADDR;
                end
            end
            ST_CHECK:    n_state = r_all_zero ? ST_EM_ADDR : ST_UPD_ADDR;
            ST_UPD_ADDR: n_state = ST_UPD_WR;
            ST_UPD_WR: begin
                if (w_cell_end) begin
                    n_state = (r_step == r_terms) ? ST_EM_ADDR : ST_MAC_ADDR;
                end else begin
                    n_state = ST_UPD_ADDR;
                end
            end
            ST_EM_ADDR:  n_state = ST_EM_LOAD;
            ST_EM_LOAD:  n_state = ST_EM_SEND;
            ST_EM_SEND: begin
                if (i_out_ready) begin
                    n_state = w_cell_end ? ST_IDLE : ST_EM_ADDR;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_dim        <= DIM_RESET;
            r_terms      <= TERMS_RESET;
            r_load_index <= '0;
            r_time       <= '0;
            r_sat        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_row        <= '0;
            r_col        <= '0;
            r_k          <= '0;
            r_step       <= '0;
            r_all_zero   <= 1'b0;
        end else begin
            r_state <= n_state;

            // register writes
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_DIM) begin
                    r_dim <= i_cfg_data[DIM_W-1:0];
                end else if (i_cfg_index == CFG_TERMS) begin
                    r_terms <= i_cfg_data[TERMS_W-1:0];
                end
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && (r_load_index == '0)) begin
                        r_time <= i_time_value;
                        r_sat  <= 1'b0;
                    end
                end
                ST_LD_WR: begin
                    if (r_load_index < w_cnt) begin
                        r_load_index <= r_load_index + 1'b1;
                        if (ovf32(w_mul_p)) r_sat <= 1'b1;
                    end
                    if (r_last) begin
                        r_load_index <= '0;
                        r_row        <= '0;
                        r_col        <= '0;
                    end
                end
                ST_INIT: begin
                    if (w_cell_end) begin
                        r_row      <= '0;
                        r_col      <= '0;
                        r_k        <= '0;
                        r_step     <= TERMS_W'(1);
                        r_all_zero <= 1'b1;
                    end else if (w_col_end) begin
                        r_col <= '0;
                        r_row <= r_row + 1'b1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                ST_MAC_ACC: begin
                    r_k <= (r_k == w_nm1) ? '0 : r_k + 1'b1;
                end
                ST_DIV_GO: begin
                    if (ovf32(r_acc)) r_sat <= 1'b1;
                end
                ST_DIV_WAIT: begin
                    if (w_div_done) begin
                        if (w_term != '0) r_all_zero <= 1'b0;
                        if (w_cell_end) begin
                            r_row <= '0;
                            r_col <= '0;
                        end else if (w_col_end) begin
                            r_col <= '0;
                            r_row <= r_row + 1'b1;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                end
                ST_UPD_WR: begin
                    if (ovf32(w_upd)) r_sat <= 1'b1;
                    if (w_cell_end) begin
                        r_row      <= '0;
                        r_col      <= '0;
                        r_step     <= r_step + 1'b1;
                        r_all_zero <= 1'b1;
                    end else if (w_col_end) begin
                        r_col <= '0;
                        r_row <= r_row + 1'b1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                ST_EM_LOAD: begin
                    r_out_valid <= 1'b1;
                end
                ST_EM_SEND: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        if (w_cell_end) begin
                            r_row <= '0;
                            r_col <= '0;
                        end else if (w_col_end) begin
                            r_col <= '0;
                            r_row <= r_row + 1'b1;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                end
                ST_LD_MUL, ST_MAC_ADDR, ST_MAC_MUL, ST_CHECK, ST_UPD_ADDR, ST_EM_ADDR: begin
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_a    <= i_a_element;
            r_last <= i_last_element;
        end
        if ((r_state == ST_INIT) && w_cell_end) begin
            r_acc <= '0;
        end else if (r_state == ST_MAC_ACC) begin
            r_acc <= r_acc + w_mul_p;
        end else if ((r_state == ST_DIV_WAIT) && w_div_done) begin
            r_acc <= '0;
        end else if ((r_state == ST_UPD_WR) && w_cell_end) begin
            r_acc <= '0;
        end
        if (r_state == ST_DIV_GO) begin
            r_neg <= w_acc_sat[DATA_W-1];
        end
        if (r_state == ST_EM_LOAD) begin
            r_f     <= w_u_rd;
            r_olast <= w_cell_end;
            r_osat  <= r_sat;
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_f_element   = r_f;
    assign o_last_result = r_olast;
    assign o_saturated   = r_osat;

    // checks
    a_out_only_in_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_state == ST_EM_SEND))
        else $error("result beat shown outside the send state");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("input taken while a result beat is pending");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV_WAIT))
        else $error("divider finished outside its wait state");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_result) |=> o_in_ready)
        else $error("not ready after the final result beat");

endmodule
